### rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // fixed field widths of the channels
  localparam int IdxFieldW = 11;
  localparam int RowFieldW = 5;
  localparam int ColFieldW = 7;
  localparam int HwFieldW  = 11;

  localparam logic       KindWrite = 1'b0;
  localparam logic       KindRead  = 1'b1;

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharBlank = 8'h20;

  localparam int TabStop = 8;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           char_code;
    logic                 end_of_string;
    logic [IdxFieldW-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           read_char;
    logic [RowFieldW-1:0] cursor_row;
    logic [ColFieldW-1:0] cursor_col;
    logic [HwFieldW-1:0]  hw_cursor_position;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

### rtl/core/tcw_ifs.sv
`default_nettype none

interface tcw_in_if;
  logic              valid;
  logic              ready;
  tcw_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcw_out_if;
  logic               valid;
  logic               ready;
  tcw_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/tcw_text_ram.sv
`default_nettype none

module tcw_text_ram #(
  parameter int  DEPTH = 2000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/text_console_writer_unit.sv
// teletype engine for a COLUMNS x ROWS text screen
// in_i carries one item: a character write (kind 0) or a cell read (kind 1).
// out_o returns exactly one result item per input item, in order.
// a write stores ordinary characters at the cursor and moves the cursor;
// line feed, carriage return and tab only move it. end_of_string on a write
// loads the linear hardware cursor after the move.
// the screen is a ring of rows in one single-port ram; scrolling moves the
// top-row base and blanks the row that becomes the bottom one.
// each item passes through accept, execute and finish states; a write that
// scrolls adds a sweep that blanks the COLUMNS cells of one row.
// every ram address comes from one shared wrap-around adder, and every
// cell access goes through the one ram port.
// after reset the block blanks the whole store, one cell a cycle, with
// in_i.ready low; cursor and hardware cursor reset to 0.
// a finished result sits in an output register; while the receiver stalls
// the block holds the next result and accepts no new item.
`default_nettype none

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o
);

  localparam int Cells = COLUMNS * ROWS;
  localparam int AddrW = $clog2(Cells);
  localparam int ColW  = $clog2(COLUMNS);
  localparam int ColNW = $clog2(COLUMNS + tcw_pkg::TabStop);
  localparam int RowW  = $clog2(ROWS);
  localparam int IdxW  = (AddrW + 1 > tcw_pkg::IdxFieldW) ? AddrW + 1 : tcw_pkg::IdxFieldW;

  tcw_pkg::state_e    state_q, state_d;
  logic [AddrW-1:0]   cnt_q, cnt_d;
  logic [AddrW-1:0]   base_q, base_d;
  logic [ColW-1:0]    cur_col_q, cur_col_d;
  logic [RowW-1:0]    cur_row_q, cur_row_d;
  logic [tcw_pkg::HwFieldW-1:0] hw_q, hw_d, hw_new;
  logic               rd_sel_q, rd_sel_d;
  logic               out_valid_q, out_valid_d;
  tcw_pkg::out_item_t out_data_q, out_data_d;
  tcw_pkg::in_item_t  item_q;
  logic               in_ready;

  // shared wrap-around address adder
  logic [AddrW-1:0]   su_a, su_b, su_sum;
  logic [AddrW:0]     su_raw;

  logic [AddrW-1:0]   lin;
  logic [ColNW-1:0]   col_ext, col_n;
  logic [RowW-1:0]    row_n;
  logic               inc_row, is_plain, scroll_need, in_range;

  logic               ram_we, ram_re;
  logic [7:0]         ram_wdata, ram_rdata;

  assign su_raw = {1'b0, su_a} + {1'b0, su_b};
  assign su_sum = (su_raw >= (AddrW + 1)'(Cells)) ? AddrW'(su_raw - (AddrW + 1)'(Cells))
                                                  : su_raw[AddrW-1:0];

  assign lin = AddrW'(cur_row_q) * AddrW'(COLUMNS) + AddrW'(cur_col_q);

  assign in_range = IdxW'(item_q.cell_index) < IdxW'(Cells);

  // cursor move for a write
  always_comb begin
    col_ext  = ColNW'(cur_col_q);
    inc_row  = 1'b0;
    is_plain = 1'b0;
    case (item_q.char_code)
      tcw_pkg::CharLf: begin
        col_n   = '0;
        inc_row = 1'b1;
      end
      tcw_pkg::CharCr: begin
        col_n = '0;
      end
      tcw_pkg::CharTab: begin
        col_n = (col_ext + ColNW'(tcw_pkg::TabStop)) & ~ColNW'(tcw_pkg::TabStop - 1);
      end
      default: begin
        col_n    = col_ext + ColNW'(1);
        is_plain = 1'b1;
      end
    endcase
    if (col_n >= ColNW'(COLUMNS)) begin
      col_n   = '0;
      inc_row = 1'b1;
    end
    scroll_need = inc_row && (cur_row_q == RowW'(ROWS - 1));
    row_n = (inc_row && !scroll_need) ? cur_row_q + RowW'(1) : cur_row_q;
  end

  always_comb begin
    hw_new = (item_q.kind == tcw_pkg::KindWrite && item_q.end_of_string)
           ? tcw_pkg::HwFieldW'(lin) : hw_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    hw_d        = hw_q;
    rd_sel_d    = rd_sel_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = item_q.char_code;
    su_a        = base_q;
    su_b        = lin;
    in_ready    = 1'b0;
    case (state_q)
      tcw_pkg::S_CLEAR: begin
        su_a      = '0;
        su_b      = cnt_q;
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::CharBlank;
        cnt_d     = cnt_q + AddrW'(1);
        if (cnt_q == AddrW'(Cells - 1)) begin
          cnt_d   = '0;
          state_d = tcw_pkg::S_IDLE;
        end
      end
      tcw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = tcw_pkg::S_EXEC;
        end
      end
      tcw_pkg::S_EXEC: begin
        if (item_q.kind == tcw_pkg::KindWrite) begin
          su_b      = lin;
          ram_we    = is_plain;
          cur_col_d = ColW'(col_n);
          cur_row_d = row_n;
          rd_sel_d  = 1'b0;
          state_d   = scroll_need ? tcw_pkg::S_SCROLL : tcw_pkg::S_FINISH;
        end else begin
          su_b     = AddrW'(item_q.cell_index);
          ram_re   = in_range;
          rd_sel_d = in_range;
          state_d  = tcw_pkg::S_FINISH;
        end
      end
      tcw_pkg::S_SCROLL: begin
        // blank the old top row, then it becomes the bottom row
        su_b      = cnt_q;
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::CharBlank;
        cnt_d     = cnt_q + AddrW'(1);
        if (cnt_q == AddrW'(COLUMNS - 1)) begin
          cnt_d   = '0;
          base_d  = (base_q == AddrW'(Cells - COLUMNS)) ? '0 : base_q + AddrW'(COLUMNS);
          state_d = tcw_pkg::S_FINISH;
        end
      end
      tcw_pkg::S_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d                   = 1'b1;
          out_data_d.read_char          = rd_sel_q ? ram_rdata : 8'h00;
          out_data_d.cursor_row         = tcw_pkg::RowFieldW'(cur_row_q);
          out_data_d.cursor_col         = tcw_pkg::ColFieldW'(cur_col_q);
          out_data_d.hw_cursor_position = hw_new;
          hw_d                          = hw_new;
          state_d                       = tcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::S_CLEAR;
      cnt_q       <= '0;
      base_q      <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      hw_q        <= '0;
      rd_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      base_q      <= base_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      hw_q        <= hw_d;
      rd_sel_q    <= rd_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      item_q <= in_i.data;
    end
    out_data_q <= out_data_d;
  end

  tcw_text_ram #(
    .DEPTH (Cells)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (su_sum),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_cursor_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cur_col_q) < COLUMNS) && (int'(cur_row_q) < ROWS))
    else $error("cursor left the screen");

  a_base_row_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(base_q) <= Cells - COLUMNS)
    else $error("top-row base out of range");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcw_pkg::S_IDLE || state_q == tcw_pkg::S_FINISH) |-> !ram_we)
    else $error("store written outside an item or sweep");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> (state_q == tcw_pkg::S_EXEC))
    else $error("accepted item not executed");

endmodule

`default_nettype wire
